>>> hw/rtl/ordered_value_list_engine_top_macros.svh
// Assertion macros for the ordered value list engine top level.
// Used by ordered_value_list_engine_top.sv; no other dependencies.
`ifndef ORDERED_VALUE_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OVLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered value list engine: check failed");

// Next-cycle implication, disabled while reset is asserted
`define OVLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered value list engine: check failed");

`endif

>>> hw/rtl/ovle_pkg.sv
// Shared constants and controller/datapath interface types for the
// ordered value list engine. No dependencies.
package ovle_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Default list capacity
  localparam int DEPTH_DEFAULT = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_ALL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic imm;        // finish the accepted request in one step
    logic walk_init;  // latch the request and start a walk
    logic walk_run;   // walk one element
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic len_zero;   // list is empty
    logic last_proc;  // final element of the walk handled this cycle
  } stat_t;

endpackage

>>> hw/rtl/ovle_ctrl.sv
// Controller state machine of the ordered value list engine.
// Depends on ovle_pkg.
module ovle_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ovle_pkg::CMD_W-1:0]     cmd_i,
  input  ovle_pkg::stat_t                stat_i,
  output ovle_pkg::ctrl_t                ctrl_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic state_q, state_d;

  assign busy = (state_q == StWalk);

  // Decode the request and sequence the walk
  always_comb begin
    state_d          = state_q;
    ctrl_o           = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          case (cmd_i) inside
            ovle_pkg::CMD_DEL_FIRST, ovle_pkg::CMD_DEL_ALL, ovle_pkg::CMD_READ: begin
              if (stat_i.len_zero) begin
                ctrl_o.imm = 1'b1;
              end else begin
                ctrl_o.walk_init = 1'b1;
                state_d          = StWalk;
              end
            end
            default: begin
              ctrl_o.imm = 1'b1;
            end
          endcase
        end
      end
      StWalk: begin
        ctrl_o.walk_run = 1'b1;
        if (stat_i.last_proc) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/ovle_datapath.sv
// Datapath of the ordered value list engine: circular element memory,
// walk counters and result registers. Depends on ovle_pkg.
module ovle_datapath #(
  parameter int DEPTH = ovle_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ovle_pkg::ctrl_t                   ctrl_i,
  output ovle_pkg::stat_t                   stat_o,
  input  logic [ovle_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [ovle_pkg::DATA_W-1:0] value_in_i,
  output logic                              res_valid_o,
  output logic [ovle_pkg::STATUS_W-1:0]     status_o,
  output logic signed [ovle_pkg::DATA_W-1:0] value_out_o,
  output logic [ovle_pkg::COUNT_W-1:0]      removed_count_o,
  output logic [ovle_pkg::COUNT_W-1:0]      length_out_o,
  output logic                              last_o
);

  localparam int IdxW   = $clog2(DEPTH);
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int DataW  = ovle_pkg::DATA_W;
  localparam int OutCnt = ovle_pkg::COUNT_W;
  localparam logic [IdxW:0]   DepthWrap = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastSlot  = IdxW'(DEPTH - 1);

  // Map a front-relative index to a memory slot
  function automatic logic [IdxW-1:0] phys_addr(input logic [IdxW-1:0] base,
                                                input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthWrap) begin
      sum = sum - DepthWrap;
    end
    return sum[IdxW-1:0];
  endfunction

  logic [DataW-1:0] mem [DEPTH];

  logic [CntW-1:0]              len_q, len_d;
  logic [IdxW-1:0]              head_q, head_d;
  logic [ovle_pkg::CMD_W-1:0]   op_q;
  logic [DataW-1:0]             val_q;
  logic [CntW-1:0]              rd_idx_q, proc_idx_q, wr_idx_q, removed_q;
  logic [CntW-1:0]              wr_idx_d, removed_d, len_m1;
  logic                         issue_q;
  logic [DataW-1:0]             rd_data_q;

  logic                         issue, proc, is_read, del_all, hit, keep, drop, last_proc;
  logic                         len_full, imm_ins, imm_app;
  logic [IdxW-1:0]              head_dec, rd_addr, wr_addr;
  logic                         wr_en;
  logic [DataW-1:0]             wr_data;

  logic                         res_vld_d;
  logic [ovle_pkg::STATUS_W-1:0] res_status_d;
  logic [DataW-1:0]             res_value_d;
  logic [CntW-1:0]              res_removed_d;
  logic                         res_last_d;

  logic                         res_vld_q;
  logic [ovle_pkg::STATUS_W-1:0] res_status_q;
  logic [DataW-1:0]             res_value_q;
  logic [OutCnt-1:0]            res_removed_q, res_len_q;
  logic                         res_last_q;

  // Walk bookkeeping
  assign len_m1    = len_q - CntW'(1);
  assign len_full  = (len_q == DepthCnt);
  assign issue     = ctrl_i.walk_run && (rd_idx_q < len_q);
  assign proc      = ctrl_i.walk_run && issue_q;
  assign last_proc = issue_q && (proc_idx_q == len_m1);
  assign is_read   = (op_q == ovle_pkg::CMD_READ);
  assign del_all   = (op_q == ovle_pkg::CMD_DEL_ALL);
  assign hit       = (rd_data_q == val_q) && (del_all || (removed_q == '0));
  assign keep      = proc && !is_read && !hit;
  assign drop      = proc && !is_read && hit;
  assign wr_idx_d  = keep ? wr_idx_q + CntW'(1) : wr_idx_q;
  assign removed_d = drop ? removed_q + CntW'(1) : removed_q;

  assign stat_o.len_zero  = (len_q == '0);
  assign stat_o.last_proc = last_proc;

  // Single-step inserts
  assign imm_ins  = ctrl_i.imm && (cmd_i == ovle_pkg::CMD_INS_FRONT) && !len_full;
  assign imm_app  = ctrl_i.imm && (cmd_i == ovle_pkg::CMD_APPEND) && !len_full;
  assign head_dec = (head_q == '0) ? LastSlot : head_q - IdxW'(1);

  // Memory port selection
  assign rd_addr = phys_addr(head_q, rd_idx_q[IdxW-1:0]);
  assign wr_en   = imm_ins || imm_app || keep;
  always_comb begin
    if (imm_ins) begin
      wr_addr = head_dec;
    end else if (imm_app) begin
      wr_addr = phys_addr(head_q, len_q[IdxW-1:0]);
    end else begin
      wr_addr = phys_addr(head_q, wr_idx_q[IdxW-1:0]);
    end
  end
  assign wr_data = ctrl_i.imm ? DataW'(value_in_i) : rd_data_q;

  // List length and front pointer
  always_comb begin
    len_d  = len_q;
    head_d = head_q;
    if (imm_ins) begin
      head_d = head_dec;
    end
    if (imm_ins || imm_app) begin
      len_d = len_q + CntW'(1);
    end else if (proc && !is_read && last_proc) begin
      len_d = wr_idx_d;
    end
  end

  // Build the next result
  always_comb begin
    res_vld_d     = 1'b0;
    res_status_d  = ovle_pkg::ST_OK;
    res_value_d   = '0;
    res_removed_d = '0;
    res_last_d    = 1'b1;
    if (ctrl_i.imm) begin
      res_vld_d = 1'b1;
      case (cmd_i) inside
        ovle_pkg::CMD_INS_FRONT, ovle_pkg::CMD_APPEND: begin
          res_status_d = len_full ? ovle_pkg::ST_FULL : ovle_pkg::ST_OK;
        end
        ovle_pkg::CMD_DEL_FIRST, ovle_pkg::CMD_DEL_ALL: begin
          res_status_d = ovle_pkg::ST_NOT_FOUND;
        end
        ovle_pkg::CMD_READ: begin
          res_status_d = ovle_pkg::ST_EMPTY;
        end
        default: begin
          res_status_d = ovle_pkg::ST_OK;
        end
      endcase
    end else if (proc && is_read) begin
      res_vld_d    = 1'b1;
      res_status_d = ovle_pkg::ST_READ;
      res_value_d  = rd_data_q;
      res_last_d   = last_proc;
    end else if (proc && last_proc) begin
      res_vld_d     = 1'b1;
      res_status_d  = (removed_d != '0) ? ovle_pkg::ST_OK : ovle_pkg::ST_NOT_FOUND;
      res_removed_d = removed_d;
    end
  end

  // Element memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      head_q     <= '0;
      rd_idx_q   <= '0;
      proc_idx_q <= '0;
      wr_idx_q   <= '0;
      removed_q  <= '0;
      issue_q    <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      len_q     <= len_d;
      head_q    <= head_d;
      res_vld_q <= res_vld_d;
      if (ctrl_i.walk_init) begin
        rd_idx_q   <= '0;
        proc_idx_q <= '0;
        wr_idx_q   <= '0;
        removed_q  <= '0;
        issue_q    <= 1'b0;
      end else if (ctrl_i.walk_run) begin
        issue_q   <= issue;
        wr_idx_q  <= wr_idx_d;
        removed_q <= removed_d;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
        if (proc) begin
          proc_idx_q <= proc_idx_q + CntW'(1);
        end
      end
    end
  end

  // Latched request and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.walk_init) begin
      op_q  <= cmd_i;
      val_q <= DataW'(value_in_i);
    end
    if (res_vld_d) begin
      res_status_q  <= res_status_d;
      res_value_q   <= res_value_d;
      res_removed_q <= OutCnt'(res_removed_d);
      res_len_q     <= OutCnt'(len_d);
      res_last_q    <= res_last_d;
    end
  end

  assign res_valid_o     = res_vld_q;
  assign status_o        = res_status_q;
  assign value_out_o     = res_value_q;
  assign removed_count_o = res_removed_q;
  assign length_out_o    = res_len_q;
  assign last_o          = res_last_q;

endmodule

>>> hw/rtl/ordered_value_list_engine_top.sv
// Ordered value list engine: an ordered list of up to DEPTH signed 32-bit
// values. Inserts at the front, appends, deletes the first or every match,
// and reads out the list front to back. A request is taken when start is
// high and busy is low. Each result sits on the result ports for one cycle,
// marked by res_valid_o, and must be taken then: there is no back-pressure.
// Insert, append, any request on an empty list that needs a walk, and unused
// codes need no walk: the result appears the cycle after the request and busy
// stays low. Deletes and read out on a list of N elements keep busy high while
// they walk the list, one element per cycle through the single read port
// of the element memory; read-out results follow one per cycle, the last
// flagged by last_o. The memory holds no reset state and needs no clearing.
// Depends on ovle_pkg, ovle_ctrl, ovle_datapath and the macros header.
`include "ordered_value_list_engine_top_macros.svh"

module ordered_value_list_engine_top #(
  parameter int DEPTH = ovle_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ovle_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [ovle_pkg::DATA_W-1:0] value_in_i,
  output logic                               res_valid_o,
  output logic [ovle_pkg::STATUS_W-1:0]      status_o,
  output logic signed [ovle_pkg::DATA_W-1:0] value_out_o,
  output logic [ovle_pkg::COUNT_W-1:0]       removed_count_o,
  output logic [ovle_pkg::COUNT_W-1:0]       length_out_o,
  output logic                               last_o
);

  localparam int OutCnt = ovle_pkg::COUNT_W;
  localparam logic [OutCnt-1:0] FullLen = OutCnt'(DEPTH);

  ovle_pkg::ctrl_t ctrl;
  ovle_pkg::stat_t stat;

  // Sequence requests
  ovle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Store elements and build results
  ovle_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_i),
    .value_in_i      (value_in_i),
    .res_valid_o     (res_valid_o),
    .status_o        (status_o),
    .value_out_o     (value_out_o),
    .removed_count_o (removed_count_o),
    .length_out_o    (length_out_o),
    .last_o          (last_o)
  );

  // Read-out results stream without gaps until the last one
  `OVLE_ASSERT_NEXT(a_stream_gapless, clk_i, rst_ni, res_valid_o && !last_o, res_valid_o)
  // A started walk holds off new requests
  `OVLE_ASSERT_NEXT(a_walk_busy, clk_i, rst_ni, ctrl.walk_init, busy)
  // A rejected insert only happens on a full list
  `OVLE_ASSERT_NOW(a_full_len, clk_i, rst_ni, res_valid_o && (status_o == ovle_pkg::ST_FULL), length_out_o == FullLen)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for ordered_value_list_engine_top: a directed table,
// then random list traffic, checked against an in-bench list predictor or a typed row.
// Depends on ovle_pkg and the RTL under hw/rtl.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ovle_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 360;
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int CLK_HALF_NS   = 4;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 20;

  // Spare command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic [COUNT_W-1:0]  removed;
    logic [COUNT_W-1:0]  length;
    logic                last;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DATA_W-1:0]   value;
    logic [7:0]          reps;
    logic                typed;
    logic [STATUS_W-1:0] exp_status;
    logic [COUNT_W-1:0]  exp_length;
  } stim_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           cmd_i;
  logic signed [DATA_W-1:0]   value_in_i;
  logic                       res_valid_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [DATA_W-1:0]   value_out_o;
  logic [COUNT_W-1:0]         removed_count_o;
  logic [COUNT_W-1:0]         length_out_o;
  logic                       last_o;

  // Predictor state: the list front to back, and the results still owed
  logic [DATA_W-1:0] shadow_list [$];
  list_result_t      step_results [$];
  list_result_t      results_due [$];
  int                mismatch_count = 0;

  // Directed table: typed expectations only where they are plain to see
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,      32'h0000_0000, 8'd1,  1'b1, ST_EMPTY,     5'd0},
    '{CMD_DEL_FIRST, 32'h0000_0005, 8'd1,  1'b1, ST_NOT_FOUND, 5'd0},
    '{CMD_DEL_ALL,   32'h0000_0005, 8'd1,  1'b1, ST_NOT_FOUND, 5'd0},
    '{CMD_SPARE_LO,  32'h0000_0000, 8'd1,  1'b1, ST_OK,        5'd0},
    '{CMD_INS_FRONT, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_OK,        5'd1},
    '{CMD_APPEND,    32'h8000_0000, 8'd1,  1'b1, ST_OK,        5'd2},
    '{CMD_INS_FRONT, 32'h0000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_APPEND,    32'hFFFF_FFFF, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_APPEND,    32'h8000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DEL_FIRST, 32'h8000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_INS_FRONT, 32'h8000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DEL_ALL,   32'h8000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_READ,      32'h0000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DEL_FIRST, 32'h0001_2345, 8'd1,  1'b1, ST_NOT_FOUND, 5'd3},
    '{CMD_APPEND,    32'hAAAA_AAAA, 8'd13, 1'b0, ST_OK,        5'd0},
    '{CMD_INS_FRONT, 32'h0000_0001, 8'd1,  1'b1, ST_FULL,      5'd16},
    '{CMD_APPEND,    32'h0000_0001, 8'd1,  1'b1, ST_FULL,      5'd16},
    '{CMD_READ,      32'h0000_0000, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DEL_ALL,   32'hAAAA_AAAA, 8'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_SPARE_HI,  32'h0000_0000, 8'd1,  1'b1, ST_OK,        5'd3}
  };

  ordered_value_list_engine_top #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .value_in_i     (value_in_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .removed_count_o(removed_count_o),
    .length_out_o   (length_out_o),
    .last_o         (last_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("Some tests failed");
    $finish;
  end

  // Build one result; the length is the list length after the request
  function automatic list_result_t make_result(input logic [STATUS_W-1:0] status,
                                               input logic [DATA_W-1:0] value,
                                               input int removed,
                                               input logic last);
    list_result_t res;
    res.status  = status;
    res.value   = value;
    res.removed = COUNT_W'(removed);
    res.length  = COUNT_W'(shadow_list.size());
    res.last    = last;
    return res;
  endfunction

  // Apply one request to the shadow list and collect the results it causes
  function automatic void predict_list_op(input logic [CMD_W-1:0] cmd,
                                          input logic [DATA_W-1:0] val);
    int hit;
    int size_before;
    step_results.delete();
    case (cmd) inside
      CMD_INS_FRONT, CMD_APPEND: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          step_results.push_back(make_result(ST_FULL, '0, 0, 1'b1));
        end else begin
          if (cmd == CMD_INS_FRONT) shadow_list.push_front(val);
          else shadow_list.push_back(val);
          step_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end
      end
      CMD_DEL_FIRST: begin
        hit = -1;
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (hit < 0) begin
          step_results.push_back(make_result(ST_NOT_FOUND, '0, 0, 1'b1));
        end else begin
          shadow_list.delete(hit);
          step_results.push_back(make_result(ST_OK, '0, 1, 1'b1));
        end
      end
      CMD_DEL_ALL: begin
        size_before = shadow_list.size();
        for (int i = size_before - 1; i >= 0; i--) begin
          if (shadow_list[i] == val) shadow_list.delete(i);
        end
        hit = size_before - shadow_list.size();
        step_results.push_back(make_result(hit != 0 ? ST_OK : ST_NOT_FOUND, '0, hit, 1'b1));
      end
      CMD_READ: begin
        if (shadow_list.size() == 0) begin
          step_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_list.size(); i++) begin
            step_results.push_back(make_result(ST_READ, shadow_list[i], 0,
                                               i == shadow_list.size() - 1));
          end
        end
      end
      default: begin
        step_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
      end
    endcase
  endfunction

  // Pick one of the spare command codes
  function automatic logic [CMD_W-1:0] pick_spare_cmd();
    return CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
  endfunction

  // Hold the request until taken, log what it owes, then maybe idle a while
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                               input bit allow_idle, input bit typed,
                               input list_result_t typed_res);
    int gap;
    start      <= 1'b1;
    cmd_i      <= cmd;
    value_in_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_list_op(cmd, val);
    if (typed) results_due.push_back(typed_res);
    else foreach (step_results[i]) results_due.push_back(step_results[i]);
    gap = (allow_idle && $urandom_range(99) < 37) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Compare each strobed result with the oldest one owed
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && res_valid_o) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d value %0d removed %0d %s %0d last %0b",
                   status_o, value_out_o, removed_count_o, "length", length_out_o,
                   last_o);
      end else begin
        want = results_due.pop_front();
        if (status_o !== want.status || value_out_o !== want.value ||
            removed_count_o !== want.removed || length_out_o !== want.length ||
            last_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected status %0d value %0d removed %0d",
                     $realtime, want.status, $signed(want.value), want.removed);
            $display("                 expected length %0d last %0b",
                     want.length, want.last);
            $display("                 actual status %0d value %0d removed %0d",
                     status_o, value_out_o, removed_count_o);
            $display("                 actual length %0d last %0b",
                     length_out_o, last_o);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random traffic, drain
  initial begin
    logic [DATA_W-1:0] value_pool [4];
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] val;
    list_result_t      typed_res;
    int                counted;
    int                issued;
    int                pick;
    int                c_ins, c_app, c_delf, c_dela, c_read;

    rst_ni     <= 1'b0;
    start      <= 1'b0;
    cmd_i      <= CMD_INS_FRONT;
    value_in_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[r]) begin
      typed_res = '{directed_rows[r].exp_status, '0, '0, directed_rows[r].exp_length, 1'b1};
      repeat (directed_rows[r].reps)
        issue_request(directed_rows[r].cmd, directed_rows[r].value, 1'b1,
                      directed_rows[r].typed, typed_res);
    end

    // Random traffic in phases that push the list toward full or empty
    counted = 0;
    issued  = 0;
    c_ins = 0; c_app = 0; c_delf = 0; c_dela = 0; c_read = 0;
    while (counted < RANDOM_ITEMS) begin
      if (issued % 40 == 0) begin
        value_pool[0] = $urandom;
        value_pool[1] = $urandom_range(3);
        case ($urandom_range(3))
          0: value_pool[2] = 32'h8000_0000;
          1: value_pool[2] = 32'h7FFF_FFFF;
          2: value_pool[2] = 32'hFFFF_FFFF;
          default: value_pool[2] = 32'h0000_0000;
        endcase
        value_pool[3] = $urandom;
        if (shadow_list.size() < 4 || (shadow_list.size() <= 12 && $urandom_range(1))) begin
          c_ins = 35; c_app = 70; c_delf = 80; c_dela = 85; c_read = 96;
        end else begin
          c_ins = 10; c_app = 20; c_delf = 55; c_dela = 75; c_read = 95;
        end
      end
      pick = $urandom_range(99);
      if (pick < c_ins)       cmd = CMD_INS_FRONT;
      else if (pick < c_app)  cmd = CMD_APPEND;
      else if (pick < c_delf) cmd = CMD_DEL_FIRST;
      else if (pick < c_dela) cmd = CMD_DEL_ALL;
      else if (pick < c_read) cmd = CMD_READ;
      else                    cmd = pick_spare_cmd();
      val = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(3)];
      issue_request(cmd, val, !(counted >= 150 && counted < 250), 1'b0, '0);
      if (cmd <= CMD_READ) counted++;
      issued++;
    end

    // Drain: wait for every owed result, then a few quiet cycles
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ovle_pkg.sv
hw/rtl/ovle_ctrl.sv
hw/rtl/ovle_datapath.sv
hw/rtl/ordered_value_list_engine_top.sv
tb/testbench.sv
